/* rtl/modbus_read_holding_responder_core_defines.svh */
// Assertion macros shared by the read holding register responder.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef MODBUS_READ_HOLDING_RESPONDER_CORE_DEFINES_SVH
`define MODBUS_READ_HOLDING_RESPONDER_CORE_DEFINES_SVH

// Plain property checked on every clock edge outside reset.
`define MRHR_ASSERT(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication checked on every clock edge outside reset.
`define MRHR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define MRHR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mrhr_pkg.sv */
// Shared types and constants of the read holding register responder.
// No dependencies; imported by every module of the block.
package mrhr_pkg;

	localparam int NUM_REGS_DEF = 16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0] SLAVE_ADDR_RST = 8'h01;
	localparam logic [4:0] REGS_IN_USE_RST = 5'd10;
	localparam logic [3:0] FRAME_LEN = 4'd8;
	localparam logic [2:0] CRC_SPAN = 3'd6;
	localparam logic [3:0] CRC_STEPS = 4'd8;

	// Input selector codes.
	localparam logic OP_RX_BYTE = 1'b0;
	localparam logic OP_REG_WRITE = 1'b1;

	// Result kinds.
	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_DROP = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_SLAVE_ADDR = 1'b0;
	localparam logic CFG_REGS_IN_USE = 1'b1;

	typedef enum logic [2:0] {
		REASON_NONE = 3'd0,
		REASON_SHORT = 3'd1,
		REASON_ADDR = 3'd2,
		REASON_CRC = 3'd3,
		REASON_RANGE = 3'd4
	} reason_t;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_JUDGE = 12'b0000_0000_0010,
		ST_DROP = 12'b0000_0000_0100,
		ST_CRC_IN = 12'b0000_0000_1000,
		ST_CHECK = 12'b0000_0001_0000,
		ST_TX_ADDR = 12'b0000_0010_0000,
		ST_TX_FUNC = 12'b0000_0100_0000,
		ST_TX_CNT = 12'b0000_1000_0000,
		ST_TX_HI = 12'b0001_0000_0000,
		ST_TX_LO = 12'b0010_0000_0000,
		ST_TX_CRCL = 12'b0100_0000_0000,
		ST_TX_CRCH = 12'b1000_0000_0000
	} state_t;

	typedef struct packed {
		logic init;
		logic start;
	} crc_ctl_t;

endpackage

/* rtl/mrhr_crc_unit.sv */
// Bit-serial CRC-16/MODBUS unit shared by request checking and reply generation.
// Depends on mrhr_pkg for the polynomial, seed and control struct.
module mrhr_crc_unit
	import mrhr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  crc_ctl_t    ctl,
	input  logic [7:0]  data,
	output logic [15:0] crc,
	output logic        busy
);

	logic [15:0] crc_q;
	logic [3:0]  steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			steps_q <= '0;
		end else if (ctl.init) begin
			crc_q <= CRC_INIT;
			steps_q <= '0;
		end else if (ctl.start) begin
			crc_q <= crc_q ^ {8'h00, data};
			steps_q <= CRC_STEPS;
		end else if (steps_q != '0) begin
			// One polynomial step per cycle, LSB first.
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
			steps_q <= steps_q - 4'd1;
		end
	end

	assign crc = crc_q;
	assign busy = (steps_q != '0);

endmodule

/* rtl/mrhr_regfile.sv */
// Holding register table with reset contents of index times 100.
// Depends on mrhr_pkg; one write port and one combinational read port.
module mrhr_regfile
	import mrhr_pkg::*;
#(
	parameter int NUM_REGS = NUM_REGS_DEF,
	parameter int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [3:0]        wr_index,
	input  logic [15:0]       wr_data,
	input  logic [RIDX_W-1:0] rd_addr,
	output logic [15:0]       rd_data
);

	logic [15:0] regs_q [NUM_REGS];

	for (genvar i = 0; i < NUM_REGS; i++) begin : g_entry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				regs_q[i] <= 16'(i * 100);
			end else if (wr_en && (5'(wr_index) == 5'(i))) begin
				regs_q[i] <= wr_data;
			end
		end
	end

	always_comb begin
		if ({1'b0, rd_addr} < (RIDX_W + 1)'(NUM_REGS)) begin
			rd_data = regs_q[rd_addr];
		end else begin
			rd_data = '0;
		end
	end

endmodule

/* rtl/modbus_read_holding_responder_core.sv */
// Modbus RTU slave answering read holding registers (function 03). Request bytes
// are gathered until tlast; a write item (tuser high) updates one holding register.
// The block stays ready for the next item after a byte without tlast. At frame end
// the block judges length and address, checks the CRC over six bytes, then sends
// the address, function and byte count bytes and two bytes per register, each also
// fed through the CRC unit, followed by the two CRC bytes; a dropped frame gives a
// single status item instead. The pace is set by one bit-serial CRC unit that
// handles one bit per cycle and is shared by request checking and reply generation.
// No item is taken while a frame is being judged or answered.
module modbus_read_holding_responder_core
	import mrhr_pkg::*;
#(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // rx_byte[7:0], reg_index[11:8], reg_value[27:12], zero
	input  logic        s_tlast,   // frame_end
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // tx_byte[7:0], drop_reason[10:8], zero
	output logic        m_tlast,   // last
	output logic        m_tuser,   // kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

`include "modbus_read_holding_responder_core_defines.svh"

	localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int CNT_W = $clog2(NUM_REGS + 1);
	localparam logic [4:0] NUM_REGS_5 = 5'(NUM_REGS);

	state_t state_q, state_d;

	logic [7:0]  slave_addr_q;
	logic [4:0]  regs_in_use_q;
	logic [7:0]  frame_q [8];
	logic [3:0]  bytes_seen_q;
	reason_t     reason_q, reason_d;
	logic        reason_set;
	logic [2:0]  crc_idx_q;
	logic        idx_inc;
	logic [CNT_W-1:0]  rem_q;
	logic [RIDX_W-1:0] ptr_q;
	logic        ctr_load, ctr_step;

	logic        out_valid_q, out_kind_q, out_last_q;
	logic [7:0]  out_tx_q;
	reason_t     out_reason_q;
	logic        out_load, out_kind_d, out_last_d;
	logic [7:0]  out_tx_d;
	logic        out_free;

	crc_ctl_t    crc_ctl;
	logic [7:0]  crc_data;
	logic [15:0] crc;
	logic        crc_busy;
	logic [15:0] rd_data;

	logic        in_acc;
	logic [7:0]  rx_byte;
	logic [3:0]  reg_index;
	logic [15:0] reg_value;
	logic [15:0] req_start, req_count;
	logic [16:0] req_end;
	logic [4:0]  limit;

	assign rx_byte = s_tdata[7:0];
	assign reg_index = s_tdata[11:8];
	assign reg_value = s_tdata[27:12];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || m_tready;

	assign req_start = {frame_q[2], frame_q[3]};
	assign req_count = {frame_q[4], frame_q[5]};
	assign req_end = {1'b0, req_start} + {1'b0, req_count};
	assign limit = (regs_in_use_q > NUM_REGS_5) ? NUM_REGS_5 : regs_in_use_q;

	mrhr_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (crc_data),
		.crc    (crc),
		.busy   (crc_busy)
	);

	mrhr_regfile #(
		.NUM_REGS (NUM_REGS),
		.RIDX_W   (RIDX_W)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_acc && (s_tuser == OP_REG_WRITE)),
		.wr_index (reg_index),
		.wr_data  (reg_value),
		.rd_addr  (ptr_q),
		.rd_data  (rd_data)
	);

	always_comb begin
		state_d = state_q;
		reason_d = reason_q;
		reason_set = 1'b0;
		crc_ctl = '0;
		crc_data = frame_q[crc_idx_q];
		idx_inc = 1'b0;
		ctr_load = 1'b0;
		ctr_step = 1'b0;
		out_load = 1'b0;
		out_kind_d = KIND_REPLY;
		out_tx_d = '0;
		out_last_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_tuser == OP_RX_BYTE) && s_tlast) begin
					state_d = ST_JUDGE;
				end
			end
			ST_JUDGE: begin
				if (bytes_seen_q != FRAME_LEN) begin
					reason_d = REASON_SHORT;
					reason_set = 1'b1;
					state_d = ST_DROP;
				end else if (frame_q[0] != slave_addr_q) begin
					reason_d = REASON_ADDR;
					reason_set = 1'b1;
					state_d = ST_DROP;
				end else begin
					crc_ctl.init = 1'b1;
					state_d = ST_CRC_IN;
				end
			end
			ST_DROP: begin
				if (out_free) begin
					out_load = 1'b1;
					out_kind_d = KIND_DROP;
					out_last_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CRC_IN: begin
				if (!crc_busy) begin
					if (crc_idx_q == CRC_SPAN) begin
						state_d = ST_CHECK;
					end else begin
						crc_ctl.start = 1'b1;
						idx_inc = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				if (crc != {frame_q[7], frame_q[6]}) begin
					reason_d = REASON_CRC;
					reason_set = 1'b1;
					state_d = ST_DROP;
				end else if (req_end > {12'h000, limit}) begin
					reason_d = REASON_RANGE;
					reason_set = 1'b1;
					state_d = ST_DROP;
				end else begin
					crc_ctl.init = 1'b1;
					ctr_load = 1'b1;
					state_d = ST_TX_ADDR;
				end
			end
			ST_TX_ADDR, ST_TX_FUNC, ST_TX_CNT, ST_TX_HI, ST_TX_LO: begin
				// Each reply byte goes out and through the CRC unit in the same cycle.
				unique case (state_q)
					ST_TX_ADDR: out_tx_d = slave_addr_q;
					ST_TX_FUNC: out_tx_d = FUNC_READ_HOLDING;
					ST_TX_CNT: out_tx_d = {frame_q[5][6:0], 1'b0};
					ST_TX_HI: out_tx_d = rd_data[15:8];
					default: out_tx_d = rd_data[7:0];
				endcase
				crc_data = out_tx_d;
				if (out_free && !crc_busy) begin
					out_load = 1'b1;
					crc_ctl.start = 1'b1;
					unique case (state_q)
						ST_TX_ADDR: state_d = ST_TX_FUNC;
						ST_TX_FUNC: state_d = ST_TX_CNT;
						ST_TX_CNT: state_d = (rem_q == '0) ? ST_TX_CRCL : ST_TX_HI;
						ST_TX_HI: state_d = ST_TX_LO;
						default: begin
							ctr_step = 1'b1;
							state_d = (rem_q == CNT_W'(1)) ? ST_TX_CRCL : ST_TX_HI;
						end
					endcase
				end
			end
			ST_TX_CRCL: begin
				out_tx_d = crc[7:0];
				if (out_free && !crc_busy) begin
					out_load = 1'b1;
					state_d = ST_TX_CRCH;
				end
			end
			ST_TX_CRCH: begin
				out_tx_d = crc[15:8];
				if (out_free) begin
					out_load = 1'b1;
					out_last_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slave_addr_q <= SLAVE_ADDR_RST;
			regs_in_use_q <= REGS_IN_USE_RST;
			bytes_seen_q <= '0;
			reason_q <= REASON_NONE;
			crc_idx_q <= '0;
			rem_q <= '0;
			ptr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SLAVE_ADDR: slave_addr_q <= cfg_data;
					CFG_REGS_IN_USE: regs_in_use_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_acc && (s_tuser == OP_RX_BYTE) && (bytes_seen_q != FRAME_LEN)) begin
				bytes_seen_q <= bytes_seen_q + 4'd1;
			end else if (state_q == ST_JUDGE) begin
				bytes_seen_q <= '0;
			end
			if (reason_set) begin
				reason_q <= reason_d;
			end
			if (crc_ctl.init) begin
				crc_idx_q <= '0;
			end else if (idx_inc) begin
				crc_idx_q <= crc_idx_q + 3'd1;
			end
			if (ctr_load) begin
				rem_q <= req_count[CNT_W-1:0];
				ptr_q <= req_start[RIDX_W-1:0];
			end else if (ctr_step) begin
				rem_q <= rem_q - CNT_W'(1);
				ptr_q <= ptr_q + RIDX_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Frame bytes and the result payload need no reset.
	always_ff @(posedge clk) begin
		if (in_acc && (s_tuser == OP_RX_BYTE) && (bytes_seen_q != FRAME_LEN)) begin
			frame_q[bytes_seen_q[2:0]] <= rx_byte;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_tx_q <= out_tx_d;
			out_reason_q <= (out_kind_d == KIND_DROP) ? reason_q : REASON_NONE;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {5'b0, out_reason_q, out_tx_q};

	`MRHR_ASSERT(a_seen_bound, clk, arst_n, bytes_seen_q <= FRAME_LEN, "byte count beyond frame length")
	`MRHR_ASSERT_IMPL(a_crc_free, clk, arst_n, crc_ctl.start, !crc_busy, "CRC unit restarted while busy")
	`MRHR_ASSERT_IMPL(a_reg_left, clk, arst_n, state_q == ST_TX_HI, rem_q != '0, "register byte with none left")
	`MRHR_ASSERT_NEXT(a_last_idle, clk, arst_n, out_load && out_last_d, state_q == ST_IDLE, "final item without return to idle")

endmodule

/* tb/modbus_reply_checker.sv */
// Checker for the read holding register responder: predicts every reply and status item
// from the accepted request, write and configuration items, and compares the results.
// Depends on mrhr_pkg for the kinds, reasons, register indexes and CRC constants.
module modbus_reply_checker
	import mrhr_pkg::*;
#(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // rx_byte[7:0], reg_index[11:8], reg_value[27:12], zero
	input  logic        s_tlast,   // frame_end
	input  logic        s_tuser,   // opcode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // tx_byte[7:0], drop_reason[10:8], zero
	input  logic        m_tlast,   // last
	input  logic        m_tuser,   // kind
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic [2:0] reason;
		logic       last;
	} reply_item_t;

	logic [7:0]  frame_store [8];
	logic [3:0]  bytes_seen;
	logic [15:0] hold_regs [NUM_REGS];
	logic [7:0]  slave_addr;
	logic [4:0]  regs_in_use;
	reply_item_t reply_q [$];
	reply_item_t want;
	logic [15:0] req_crc;
	logic [15:0] reply_crc;
	logic [15:0] word;
	int          req_start;
	int          req_count;
	int          reg_limit;

	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic report_error(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic push_result(logic kind, logic [7:0] b, logic [2:0] reason, logic last);
		reply_item_t r;
		r.kind = kind;
		r.tx_byte = b;
		r.reason = reason;
		r.last = last;
		reply_q.push_back(r);
	endtask

	task automatic push_reply_byte(logic [7:0] b);
		push_result(KIND_REPLY, b, REASON_NONE, 1'b0);
		reply_crc = crc16_step(reply_crc, b);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				frame_store[i] = 8'h00;
			for (int i = 0; i < NUM_REGS; i++)
				hold_regs[i] = 16'(i * 100);
			bytes_seen = 4'd0;
			slave_addr = SLAVE_ADDR_RST;
			regs_in_use = REGS_IN_USE_RST;
			reply_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SLAVE_ADDR)
					slave_addr = cfg_data;
				else
					regs_in_use = cfg_data[4:0];
			end

			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					report_error($sformatf("item with none expected: kind %0d byte %02h last %0d",
						m_tuser, m_tdata[7:0], m_tlast));
				end else begin
					want = reply_q.pop_front();
					if (m_tuser !== want.kind)
						report_error($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
					if (m_tdata[7:0] !== want.tx_byte)
						report_error($sformatf("tx_byte %02h, expected %02h",
							m_tdata[7:0], want.tx_byte));
					if (m_tdata[10:8] !== want.reason)
						report_error($sformatf("drop_reason %0d, expected %0d",
							m_tdata[10:8], want.reason));
					if (m_tlast !== want.last)
						report_error($sformatf("last %0d, expected %0d", m_tlast, want.last));
				end
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == OP_REG_WRITE) begin
					if (s_tdata[11:8] < NUM_REGS)
						hold_regs[s_tdata[11:8]] = s_tdata[27:12];
				end else begin
					// Only the first eight bytes of a frame are kept.
					if (bytes_seen < FRAME_LEN) begin
						frame_store[bytes_seen[2:0]] = s_tdata[7:0];
						bytes_seen++;
					end
					if (s_tlast) begin
						req_crc = CRC_INIT;
						for (int i = 0; i < 6; i++)
							req_crc = crc16_step(req_crc, frame_store[i]);
						req_start = {frame_store[2], frame_store[3]};
						req_count = {frame_store[4], frame_store[5]};
						reg_limit = (regs_in_use > NUM_REGS) ? NUM_REGS : regs_in_use;
						if (bytes_seen < FRAME_LEN)
							push_result(KIND_DROP, 8'h00, REASON_SHORT, 1'b1);
						else if (frame_store[0] != slave_addr)
							push_result(KIND_DROP, 8'h00, REASON_ADDR, 1'b1);
						else if (req_crc != {frame_store[7], frame_store[6]})
							push_result(KIND_DROP, 8'h00, REASON_CRC, 1'b1);
						else if (req_start + req_count > reg_limit)
							push_result(KIND_DROP, 8'h00, REASON_RANGE, 1'b1);
						else begin
							reply_crc = CRC_INIT;
							push_reply_byte(slave_addr);
							push_reply_byte(FUNC_READ_HOLDING);
							push_reply_byte(8'(req_count * 2));
							for (int i = 0; i < req_count; i++) begin
								word = hold_regs[(req_start + i) % NUM_REGS];
								push_reply_byte(word[15:8]);
								push_reply_byte(word[7:0]);
							end
							push_result(KIND_REPLY, reply_crc[7:0], REASON_NONE, 1'b0);
							push_result(KIND_REPLY, reply_crc[15:8], REASON_NONE, 1'b1);
						end
						bytes_seen = 4'd0;
					end
				end
			end

			pending <= reply_q.size();
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the read holding register responder testbench: clock, reset, request and
// configuration stimulus, reply back-pressure, watchdog and verdict.
// Depends on mrhr_pkg, modbus_read_holding_responder_core and modbus_reply_checker.
module testbench;
	import mrhr_pkg::*;

	localparam int REG_COUNT = NUM_REGS_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 100;
	localparam int ITEMS_PER_PHASE = 38;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'h0;
	logic        s_tlast = 1'b0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = 8'h00;
	int          fail_count;
	int          pending;

	logic [7:0]  frame_buf [$];
	logic [7:0]  slave_now = SLAVE_ADDR_RST;
	logic [4:0]  regs_now = REGS_IN_USE_RST;
	bit          tight = 1'b0;
	int          items_sent = 0;

	modbus_read_holding_responder_core #(.NUM_REGS(REG_COUNT)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	modbus_reply_checker #(.NUM_REGS(REG_COUNT)) reply_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic send_item(logic op, logic [7:0] rx, logic fend, logic [3:0] idx,
			logic [15:0] val);
		int gap;
		gap = tight ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tlast <= fend;
		s_tdata <= {4'h0, val, idx, rx};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_write();
		send_item(OP_REG_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
	endtask

	// Sends the first n bytes of frame_buf, the last of them marked as frame end.
	task automatic send_frame(bit mix_writes, int n);
		for (int i = 0; i < n; i++) begin
			if (mix_writes && $urandom_range(0, 5) == 0)
				send_write();
			send_item(OP_RX_BYTE, frame_buf[i], i == n - 1, 4'($urandom_range(0, 15)),
				16'($urandom_range(0, 65535)));
		end
	endtask

	task automatic build_request(logic [7:0] addr, logic [7:0] func, logic [15:0] start,
			logic [15:0] count);
		logic [15:0] crc;
		frame_buf.delete();
		frame_buf.push_back(addr);
		frame_buf.push_back(func);
		frame_buf.push_back(start[15:8]);
		frame_buf.push_back(start[7:0]);
		frame_buf.push_back(count[15:8]);
		frame_buf.push_back(count[7:0]);
		crc = CRC_INIT;
		for (int i = 0; i < 6; i++)
			crc = crc_update(crc, frame_buf[i]);
		frame_buf.push_back(crc[7:0]);
		frame_buf.push_back(crc[15:8]);
	endtask

	// Stops the request stream and waits until every reply has arrived and the block
	// has had time to finish whatever it was still doing.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(logic idx, logic [7:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SLAVE_ADDR)
			slave_now = data;
		else
			regs_now = data[4:0];
	endtask

	task automatic random_action();
		int pick;
		int lim;
		int start;
		int count;
		int extra;
		logic [7:0] func;
		lim = (regs_now > REG_COUNT) ? REG_COUNT : regs_now;
		start = $urandom_range(0, lim);
		count = $urandom_range(0, lim - start);
		func = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : FUNC_READ_HOLDING;
		tight = ($urandom_range(0, 4) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			build_request(slave_now, func, 16'(start), 16'(count));
			send_frame(1'b1, frame_buf.size());
		end else if (pick < 60) begin
			case ($urandom_range(0, 2))
				0: count = lim - start + 1 + $urandom_range(0, 3);
				1: begin
					start = $urandom_range(lim + 1, 65535);
					count = $urandom_range(0, 65535);
				end
				default: count = $urandom_range(lim + 1, 65535);
			endcase
			build_request(slave_now, func, 16'(start), 16'(count));
			send_frame(1'b1, frame_buf.size());
		end else if (pick < 68) begin
			// One flipped bit somewhere in the CRC field.
			build_request(slave_now, func, 16'(start), 16'(count));
			extra = $urandom_range(0, 15);
			frame_buf[6 + extra / 8] = frame_buf[6 + extra / 8] ^ 8'(1 << (extra % 8));
			send_frame(1'b0, frame_buf.size());
		end else if (pick < 76) begin
			build_request(slave_now ^ 8'($urandom_range(1, 255)), func, 16'(start),
				16'(count));
			send_frame(1'b0, frame_buf.size());
		end else if (pick < 83) begin
			build_request(slave_now, func, 16'(start), 16'(count));
			send_frame(1'b0, $urandom_range(1, 7));
		end else if (pick < 89) begin
			build_request(slave_now, func, 16'(start), 16'(count));
			repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(0, 255)));
			send_frame(1'b1, frame_buf.size());
		end else if (pick < 94) begin
			frame_buf.delete();
			repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom_range(0, 255)));
			send_frame(1'b1, frame_buf.size());
		end else begin
			repeat ($urandom_range(1, 3)) send_write();
		end
	endtask

	initial begin : stimulus
		int goal;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: begin
					program_reg(CFG_SLAVE_ADDR, 8'hFF);
					program_reg(CFG_REGS_IN_USE, 8'd16);
				end
				2: begin
					program_reg(CFG_SLAVE_ADDR, 8'h00);
					program_reg(CFG_REGS_IN_USE, 8'd0);
				end
				3: begin
					program_reg(CFG_SLAVE_ADDR, 8'($urandom_range(0, 255)));
					program_reg(CFG_REGS_IN_USE, 8'd1);
				end
				4: begin
					program_reg(CFG_SLAVE_ADDR, 8'($urandom_range(0, 255)));
					program_reg(CFG_REGS_IN_USE, 8'($urandom_range(2, 15)));
				end
				5: begin
					program_reg(CFG_SLAVE_ADDR, 8'($urandom_range(0, 255)));
					program_reg(CFG_REGS_IN_USE, 8'($urandom_range(0, 16)));
				end
				default: begin
					// Write with frame end set, then a one-byte frame.
					send_item(OP_REG_WRITE, 8'hFF, 1'b1, 4'd9, 16'hFFFF);
					send_item(OP_RX_BYTE, 8'h00, 1'b1, 4'hF, 16'hFFFF);
					build_request(slave_now, FUNC_READ_HOLDING, 16'd8, 16'd2);
					send_frame(1'b0, frame_buf.size());
					// Zero count at the top of the table, with a byte past the eighth.
					build_request(slave_now, FUNC_READ_HOLDING, 16'd10, 16'd0);
					frame_buf.push_back(8'hA5);
					send_frame(1'b0, frame_buf.size());
					build_request(8'hFE, FUNC_READ_HOLDING, 16'd0, 16'd1);
					send_frame(1'b0, frame_buf.size());
				end
			endcase
			goal = items_sent + ITEMS_PER_PHASE;
			while (items_sent < goal) random_action();
		end
		drain();
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : reply_sink
		int stall;
		@(posedge clk);
		forever begin
			stall = gap_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6))
				@(posedge clk);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/mrhr_pkg.sv
rtl/mrhr_crc_unit.sv
rtl/mrhr_regfile.sv
rtl/modbus_read_holding_responder_core.sv
tb/modbus_reply_checker.sv
tb/testbench.sv
